// File: rtl/core/nrd_pkg.sv
// shared constants and types for the numeric character reference decoder
`default_nettype none

package nrd_pkg;

  localparam int MAX_REF_LEN = 16;
  localparam int MAX_DIGITS  = MAX_REF_LEN - 2;
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W       = $clog2(MAX_DIGITS);

  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_SEMI  = 8'h3b;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] BYTE_MAX   = 8'hff;

  localparam logic [7:0] OOR_RESET  = CHAR_SPACE;

  // register byte address bit that selects the register index
  localparam int ADDR_W = 3;
  localparam logic REG_OUT_OF_RANGE = 1'b0;

  // what one accepted byte asks the emitter to send, in this order:
  // '&', '#', held digits, one byte, trailing '&'
  typedef struct packed {
    logic             pre_amp;
    logic             pre_hash;
    logic [CNT_W-1:0] n_digits;
    logic             mid_valid;
    logic [7:0]       mid_byte;
    logic             tail_amp;
    logic             eot;
  } plan_t;

endpackage

`default_nettype wire

// File: rtl/core/numeric_char_ref_decoder_core.sv
// top level of the numeric character reference decoder
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   s_tdata[7:0] char_in, s_tlast end_of_text
//  m_*      out  m_tvalid/m_tready   m_tdata[7:0] char_out, m_tlast last_of_run,
//                                    m_tuser text_done
//  apb      in   psel/penable        reg 0 at address 0: out_of_range_char
//
// a transaction that yields output bytes holds the sequencer until all are sent; one
// that yields none leaves it free; held digits drain from the head of the cell chain
// one per stall-free cycle, so a failed reference yields up to MAX_REF_LEN+1 bytes.
// s_tready is low while the sequencer still has bytes to send; the output register
// lets the next transaction in while the last byte waits for m_tready.
// rst is synchronous and clears the parser mode, the sequencer and the output valid.
`default_nettype none

module numeric_char_ref_decoder_core import nrd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,   // [7:0] char_in
  input  wire logic              s_tlast,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [7:0]        m_tdata,   // [7:0] char_out
  output logic                   m_tlast,
  output logic                   m_tuser,   // [0] text_done
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  logic [7:0]       out_of_range_char;
  logic             accept;
  logic             busy;
  logic             shift;
  plan_t            plan;
  logic             digit_wr;
  logic [IDX_W-1:0] digit_wr_idx;
  logic [3:0]       digit_wr_val;
  logic [3:0]       cell_digit [MAX_DIGITS];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_of_range_char <= OOR_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_OUT_OF_RANGE)) begin
      out_of_range_char <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_OUT_OF_RANGE) ? {24'h000000, out_of_range_char} : 32'h0;

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;

  nrd_parser u_parser (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .char_in           (s_tdata),
    .end_of_text       (s_tlast),
    .out_of_range_char (out_of_range_char),
    .plan              (plan),
    .digit_wr          (digit_wr),
    .digit_wr_idx      (digit_wr_idx),
    .digit_wr_val      (digit_wr_val)
  );

  // digits enter at the fill position and move toward cell 0 while draining
  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    logic [3:0] from_next;
    if (i == MAX_DIGITS - 1) begin : g_tail
      assign from_next = 4'h0;
    end else begin : g_mid
      assign from_next = cell_digit[i+1];
    end
    nrd_digit_cell u_cell (
      .clk       (clk),
      .wr_en     (digit_wr && (digit_wr_idx == IDX_W'(i))),
      .wr_digit  (digit_wr_val),
      .shift     (shift),
      .from_next (from_next),
      .digit     (cell_digit[i])
    );
  end

  nrd_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .plan       (plan),
    .head_digit (cell_digit[0]),
    .busy       (busy),
    .shift      (shift),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .out_last   (m_tlast),
    .out_done   (m_tuser)
  );

endmodule

`default_nettype wire

// File: rtl/core/nrd_digit_cell.sv
// one storage cell of the held digit chain
`default_nettype none

module nrd_digit_cell import nrd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       wr_en,
  input  wire logic [3:0] wr_digit,
  input  wire logic       shift,
  input  wire logic [3:0] from_next,
  output logic      [3:0] digit
);

  // a write only happens while the chain is not draining
  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit <= wr_digit;
    end else if (shift) begin
      digit <= from_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/nrd_parser.sv
// reference parser: mode, digit count and value, plans the bytes of each transaction
`default_nettype none

module nrd_parser import nrd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [7:0]       char_in,
  input  wire logic             end_of_text,
  input  wire logic [7:0]       out_of_range_char,
  output plan_t                 plan,
  output logic                  digit_wr,
  output logic [IDX_W-1:0]      digit_wr_idx,
  output logic [3:0]            digit_wr_val
);

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_AMP    = 2'd1;
  localparam logic [1:0] MODE_DIGITS = 2'd2;

  logic [1:0]       parse_mode, parse_mode_next;
  logic [CNT_W-1:0] digit_count, digit_count_next;
  logic [7:0]       ref_value, ref_value_next;
  logic             value_overflow, value_overflow_next;

  logic             is_digit;
  logic [11:0]      acc;
  logic             store;

  assign is_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
  // value * 10 + digit
  assign acc = {1'b0, ref_value, 3'b000} + {3'b000, ref_value, 1'b0} + {8'h00, char_in[3:0]};

  always_comb begin
    plan                = '0;
    plan.eot            = end_of_text;
    parse_mode_next     = parse_mode;
    digit_count_next    = digit_count;
    ref_value_next      = ref_value;
    value_overflow_next = value_overflow;
    store               = 1'b0;
    case (parse_mode)
      MODE_DIGITS: begin
        if (is_digit && (digit_count < CNT_W'(MAX_DIGITS))) begin
          store            = 1'b1;
          digit_count_next = digit_count + CNT_W'(1);
          if (acc > {4'h0, BYTE_MAX}) begin
            value_overflow_next = 1'b1;
          end else begin
            ref_value_next = acc[7:0];
          end
        end else if ((char_in == CHAR_SEMI) && (digit_count != '0)) begin
          plan.mid_valid   = 1'b1;
          plan.mid_byte    = value_overflow ? out_of_range_char : ref_value;
          parse_mode_next  = MODE_IDLE;
          digit_count_next = '0;
        end else begin
          // failed candidate: release what is held, then take the byte afresh
          plan.pre_amp     = 1'b1;
          plan.pre_hash    = 1'b1;
          plan.n_digits    = digit_count;
          digit_count_next = '0;
          if (char_in == CHAR_AMP) begin
            parse_mode_next = MODE_AMP;
          end else begin
            parse_mode_next = MODE_IDLE;
            plan.mid_valid  = 1'b1;
            plan.mid_byte   = char_in;
          end
        end
      end
      MODE_AMP: begin
        if (char_in == CHAR_HASH) begin
          parse_mode_next     = MODE_DIGITS;
          digit_count_next    = '0;
          ref_value_next      = '0;
          value_overflow_next = 1'b0;
        end else begin
          plan.pre_amp = 1'b1;
          if (char_in == CHAR_AMP) begin
            parse_mode_next = MODE_AMP;
          end else begin
            parse_mode_next = MODE_IDLE;
            plan.mid_valid  = 1'b1;
            plan.mid_byte   = char_in;
          end
        end
      end
      default: begin
        if (char_in == CHAR_AMP) begin
          parse_mode_next = MODE_AMP;
        end else begin
          parse_mode_next = MODE_IDLE;
          plan.mid_valid  = 1'b1;
          plan.mid_byte   = char_in;
        end
      end
    endcase

    // end of text flushes whatever the byte left held
    if (end_of_text) begin
      if (parse_mode_next == MODE_DIGITS) begin
        // only reached with nothing planned yet
        plan.pre_amp  = 1'b1;
        plan.pre_hash = 1'b1;
        plan.n_digits = digit_count_next;
      end else if (parse_mode_next == MODE_AMP) begin
        plan.tail_amp = 1'b1;
      end
      parse_mode_next  = MODE_IDLE;
      digit_count_next = '0;
    end
  end

  assign digit_wr     = accept && store;
  assign digit_wr_idx = digit_count[IDX_W-1:0];
  assign digit_wr_val = char_in[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode     <= MODE_IDLE;
      digit_count    <= '0;
      ref_value      <= '0;
      value_overflow <= 1'b0;
    end else if (accept) begin
      parse_mode     <= parse_mode_next;
      digit_count    <= digit_count_next;
      ref_value      <= ref_value_next;
      value_overflow <= value_overflow_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/nrd_emitter.sv
// result sequencer: walks the plan of a transaction and feeds the output register
`default_nettype none

module nrd_emitter import nrd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire plan_t      plan,
  input  wire logic [3:0] head_digit,
  output logic            busy,
  output logic            shift,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            out_done
);

  logic             p_amp, p_hash, p_mid, p_tail, p_eot;
  logic [CNT_W-1:0] p_dig;
  logic [7:0]       mid_byte;

  logic             advance;
  logic             rest_empty;
  logic [7:0]       sel_byte;
  logic             take_amp, take_hash, take_dig, take_mid, take_tail;

  assign busy    = p_amp || p_hash || (p_dig != '0) || p_mid || p_tail;
  assign advance = busy && (!out_valid || out_ready);

  always_comb begin
    take_amp  = p_amp;
    take_hash = !p_amp && p_hash;
    take_dig  = !p_amp && !p_hash && (p_dig != '0);
    take_mid  = !p_amp && !p_hash && (p_dig == '0) && p_mid;
    take_tail = !p_amp && !p_hash && (p_dig == '0) && !p_mid && p_tail;
    sel_byte  = CHAR_AMP;
    if (take_hash) begin
      sel_byte = CHAR_HASH;
    end else if (take_dig) begin
      sel_byte = CHAR_ZERO + {4'h0, head_digit};
    end else if (take_mid) begin
      sel_byte = mid_byte;
    end
    // nothing else queued behind the byte picked now
    rest_empty = ((p_hash && !take_hash) == 1'b0)
              && ((p_dig - (take_dig ? CNT_W'(1) : CNT_W'(0))) == '0)
              && ((p_mid && !take_mid) == 1'b0)
              && ((p_tail && !take_tail) == 1'b0)
              && !take_amp;
    if (take_amp) begin
      rest_empty = !p_hash && (p_dig == '0) && !p_mid && !p_tail;
    end
  end

  assign shift = advance && take_dig;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_amp     <= 1'b0;
      p_hash    <= 1'b0;
      p_dig     <= '0;
      p_mid     <= 1'b0;
      p_tail    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        p_amp  <= plan.pre_amp;
        p_hash <= plan.pre_hash;
        p_dig  <= plan.n_digits;
        p_mid  <= plan.mid_valid;
        p_tail <= plan.tail_amp;
      end else if (advance) begin
        if (take_amp) begin
          p_amp <= 1'b0;
        end
        if (take_hash) begin
          p_hash <= 1'b0;
        end
        if (take_dig) begin
          p_dig <= p_dig - CNT_W'(1);
        end
        if (take_mid) begin
          p_mid <= 1'b0;
        end
        if (take_tail) begin
          p_tail <= 1'b0;
        end
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mid_byte <= plan.mid_byte;
      p_eot    <= plan.eot;
    end
    if (advance) begin
      out_byte <= sel_byte;
      out_last <= rest_empty;
      out_done <= rest_empty && p_eot;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/nrd_checker.sv
// port-level checks for the numeric character reference decoder
`default_nettype none

module nrd_checker import nrd_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       s_tlast,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast,
  input wire logic       m_tuser
);

  // end of text closes the run of its transaction
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("text_done without last_of_run");

  // a final input always yields output, so the sequencer is busy right after
  a_eot_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input ready right after end of text");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled output changed");

endmodule

bind numeric_char_ref_decoder_core nrd_checker u_nrd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

`default_nettype wire
